FILE: src/rtc_pkg.sv
// Shared types and operation codes for the calendar counter.
// No dependencies; every other file of the block imports this package.

package rtc_pkg;

    // Operation codes carried in the operation field of an input word.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Register indexes of the configuration port.
    localparam logic CFG_TWELVE_HOUR = 1'b0;
    localparam logic CFG_BCD         = 1'b1;

    // Calendar time in binary, 24-hour form.
    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
        logic [6:0] century;
    } rtc_time_t;

    // Raw clock bytes of a load word.
    typedef struct packed {
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] weekday;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] century;
    } rtc_raw_t;

    // Load format controls from the configuration registers.
    typedef struct packed {
        logic twelve_hour;
        logic bcd;
    } rtc_mode_t;

endpackage

FILE: src/rtc_load_decode.sv
// Load path: turns eight raw clock bytes into a clamped binary time.
// Depends on rtc_pkg for the raw, time and mode types.

module rtc_load_decode
    import rtc_pkg::*;
(
    input  rtc_raw_t  raw,
    input  rtc_mode_t mode,
    output rtc_time_t load_time
);

    localparam logic [7:0] SEC_MAX     = 8'd59;
    localparam logic [7:0] HOUR_MAX    = 8'd23;
    localparam logic [7:0] WEEKDAY_MAX = 8'd7;
    localparam logic [7:0] DAY_MAX     = 8'd31;
    localparam logic [7:0] MONTH_MAX   = 8'd12;
    localparam logic [7:0] YEAR_MAX    = 8'd99;
    localparam logic [7:0] NOON        = 8'd12;
    localparam logic [7:0] ONE         = 8'd1;
    localparam logic [7:0] ZERO        = 8'd0;

    // Packed BCD to binary; digits above nine are taken at face value.
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] hi;
        begin
            hi = {4'b0000, b[7:4]};
            return (hi << 3) + (hi << 1) + {4'b0000, b[3:0]};
        end
    endfunction

    function automatic logic [7:0] clamp(input logic [7:0] v, input logic [7:0] lo,
                                         input logic [7:0] hi);
        begin
            if (v < lo)
                return lo;
            else if (v > hi)
                return hi;
            else
                return v;
        end
    endfunction

    rtc_raw_t   v;
    logic       pm;
    logic [7:0] hour_24;

    // Strip the PM flag, convert from BCD, then move to 24-hour form.
    always_comb
    begin
        v  = raw;
        pm = 1'b0;
        if (mode.twelve_hour)
        begin
            pm     = raw.hour[7];
            v.hour = {1'b0, raw.hour[6:0]};
        end
        if (mode.bcd)
        begin
            v.second  = bcd_to_bin(v.second);
            v.minute  = bcd_to_bin(v.minute);
            v.hour    = bcd_to_bin(v.hour);
            v.weekday = bcd_to_bin(v.weekday);
            v.day     = bcd_to_bin(v.day);
            v.month   = bcd_to_bin(v.month);
            v.year    = bcd_to_bin(v.year);
            v.century = bcd_to_bin(v.century);
        end
        hour_24 = v.hour;
        if (mode.twelve_hour)
        begin
            // Only PM hours other than noon move up; midnight AM becomes zero.
            if (pm && (v.hour != NOON))
                hour_24 = v.hour + NOON;
            else if (!pm && (v.hour == NOON))
                hour_24 = ZERO;
        end
    end

    // Clamp each field into its legal range.
    always_comb
    begin
        logic [7:0] c_sec;
        logic [7:0] c_min;
        logic [7:0] c_hour;
        logic [7:0] c_wd;
        logic [7:0] c_day;
        logic [7:0] c_mon;
        logic [7:0] c_year;
        logic [7:0] c_cent;
        c_sec  = clamp(v.second, ZERO, SEC_MAX);
        c_min  = clamp(v.minute, ZERO, SEC_MAX);
        c_hour = clamp(hour_24, ZERO, HOUR_MAX);
        c_wd   = clamp(v.weekday, ONE, WEEKDAY_MAX);
        c_day  = clamp(v.day, ONE, DAY_MAX);
        c_mon  = clamp(v.month, ONE, MONTH_MAX);
        c_year = clamp(v.year, ZERO, YEAR_MAX);
        c_cent = clamp(v.century, ZERO, YEAR_MAX);
        load_time.second  = c_sec[5:0];
        load_time.minute  = c_min[5:0];
        load_time.hour    = c_hour[4:0];
        load_time.weekday = c_wd[2:0];
        load_time.day     = c_day[4:0];
        load_time.month   = c_mon[3:0];
        load_time.year    = c_year[6:0];
        load_time.century = c_cent[6:0];
    end

endmodule

FILE: src/rtc_tick_advance.sv
// Tick path: advances a calendar time by one second with cascaded rollover.
// Depends on rtc_pkg for the time type.

module rtc_tick_advance
    import rtc_pkg::*;
(
    input  rtc_time_t cur,
    output rtc_time_t nxt,
    output logic      resync
);

    localparam logic [5:0] SEC_LIMIT     = 6'd60;
    localparam logic [5:0] RESYNC_SECOND = 6'd30;
    localparam logic [4:0] HOUR_LIMIT    = 5'd24;
    localparam logic [3:0] WEEKDAY_MAX   = 4'd7;
    localparam logic [3:0] MONTH_MAX     = 4'd12;
    localparam logic [6:0] YEAR_LIMIT    = 7'd100;
    localparam logic [6:0] CENTURY_MAX   = 7'd99;

    // Gregorian month length; year zero of a century leaps by the century.
    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic [6:0] year,
                                                input logic [6:0] century);
        logic leap;
        begin
            leap = (year[1:0] == 2'b00) &&
                   ((year != 7'd0) || (century[1:0] == 2'b00));
            case (month)
                4'd2:    return leap ? 5'd29 : 5'd28;
                4'd4,
                4'd6,
                4'd9,
                4'd11:   return 5'd30;
                default: return 5'd31;
            endcase
        end
    endfunction

    logic [5:0] sec_inc;
    logic [5:0] min_inc;
    logic [4:0] hour_inc;
    logic [3:0] wd_inc;
    logic [5:0] day_inc;
    logic [3:0] mon_inc;
    logic [6:0] year_inc;
    logic [6:0] cent_inc;
    logic [4:0] mon_len;

    assign sec_inc  = cur.second + 6'd1;
    assign min_inc  = cur.minute + 6'd1;
    assign hour_inc = cur.hour + 5'd1;
    assign wd_inc   = {1'b0, cur.weekday} + 4'd1;
    assign day_inc  = {1'b0, cur.day} + 6'd1;
    assign mon_inc  = cur.month + 4'd1;
    assign year_inc = cur.year + 7'd1;
    assign cent_inc = cur.century + 7'd1;
    assign mon_len  = month_length(cur.month, cur.year, cur.century);

    assign resync = (sec_inc == RESYNC_SECOND);

    // Each field rolls over only when every field below it has.
    always_comb
    begin
        nxt = cur;
        if (sec_inc != SEC_LIMIT)
            nxt.second = sec_inc;
        else
        begin
            nxt.second = 6'd0;
            if (min_inc != SEC_LIMIT)
                nxt.minute = min_inc;
            else
            begin
                nxt.minute = 6'd0;
                if (hour_inc != HOUR_LIMIT)
                    nxt.hour = hour_inc;
                else
                begin
                    nxt.hour    = 5'd0;
                    nxt.weekday = (wd_inc > WEEKDAY_MAX) ? 3'd1 : wd_inc[2:0];
                    if (day_inc <= {1'b0, mon_len})
                        nxt.day = day_inc[4:0];
                    else
                    begin
                        nxt.day = 5'd1;
                        if (mon_inc <= MONTH_MAX)
                            nxt.month = mon_inc;
                        else
                        begin
                            nxt.month = 4'd1;
                            if (year_inc != YEAR_LIMIT)
                                nxt.year = year_inc;
                            else
                            begin
                                nxt.year    = 7'd0;
                                nxt.century = (cent_inc > CENTURY_MAX) ? 7'd0 : cent_inc;
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

FILE: src/rtc_calendar_counter.sv
// Top level of the calendar counter: handshakes, configuration and time state.
// Depends on rtc_pkg, rtc_load_decode and rtc_tick_advance.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word: an operation code
//   (tick or load) and eight raw clock bytes, which only a load uses.
//   Output channel (out_valid / out_stall) returns one word per input word:
//   the time after that word, a resync request and a tick flag.
//   The configuration port (cfg_write, cfg_index, cfg_data) sets 12-hour and
//   BCD load formats; write it only while no word is in flight.
// Timing:
//   A word is registered in the input register on acceptance, and its result
//   is registered in the result register once that register is free.
//   One word per cycle is sustained while out_stall is low; the combinational
//   tick/load update of the time registers between the two registers sets this.
// Reset clears both stages and sets the time to 00:00:00, weekday 1,
// day 1, month 1, year 0, century 0, with both formats off.
// When the receiver stalls, the result holds and one more word may wait in
// the input register; after that in_stall is raised.

module rtc_calendar_counter
    import rtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [7:0] raw_second,
    input  logic [7:0] raw_minute,
    input  logic [7:0] raw_hour,
    input  logic [7:0] raw_weekday,
    input  logic [7:0] raw_day,
    input  logic [7:0] raw_month,
    input  logic [7:0] raw_year,
    input  logic [7:0] raw_century,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [5:0] second_out,
    output logic [5:0] minute_out,
    output logic [4:0] hour_out,
    output logic [2:0] weekday_out,
    output logic [4:0] day_out,
    output logic [3:0] month_out,
    output logic [6:0] year_out,
    output logic [6:0] century_out,
    output logic       resync_request,
    output logic       tick_event,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic       cfg_data
);

    localparam rtc_time_t TIME_RESET = '{second: 6'd0, minute: 6'd0, hour: 5'd0,
                                         weekday: 3'd1, day: 5'd1, month: 4'd1,
                                         year: 7'd0, century: 7'd0};

    rtc_mode_t mode_reg;
    logic      s1_valid_reg;
    logic      s1_valid_next;
    logic      s1_op_reg;
    rtc_raw_t  s1_raw_reg;
    rtc_raw_t  raw_in;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      out_resync_reg;
    logic      out_tick_reg;
    rtc_time_t time_reg;
    rtc_time_t time_next;
    rtc_time_t load_time;
    rtc_time_t tick_time;
    logic      tick_resync;
    logic      out_free;
    logic      s1_move;
    logic      in_accept;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= '0;
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TWELVE_HOUR: mode_reg.twelve_hour <= cfg_data;
                CFG_BCD:         mode_reg.bcd         <= cfg_data;
                default:         mode_reg             <= mode_reg;
            endcase
        end
    end

    // Flow control: the result register frees when empty or being taken.
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next  = in_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);

    assign raw_in = '{second: raw_second, minute: raw_minute, hour: raw_hour,
                      weekday: raw_weekday, day: raw_day, month: raw_month,
                      year: raw_year, century: raw_century};

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg  <= operation;
            s1_raw_reg <= raw_in;
        end
    end

    rtc_load_decode u_load (
        .raw       (s1_raw_reg),
        .mode      (mode_reg),
        .load_time (load_time)
    );

    rtc_tick_advance u_tick (
        .cur    (time_reg),
        .nxt    (tick_time),
        .resync (tick_resync)
    );

    assign time_next = (s1_op_reg == OP_LOAD) ? load_time : tick_time;

    // Time state; it changes only when a result word is loaded, so it also
    // serves as the time fields of the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= TIME_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s1_move)
                time_reg <= time_next;
        end
    end

    // Result flags.
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_tick_reg   <= (s1_op_reg == OP_TICK);
            out_resync_reg <= (s1_op_reg == OP_TICK) && tick_resync;
        end
    end

    assign out_valid      = out_valid_reg;
    assign second_out     = time_reg.second;
    assign minute_out     = time_reg.minute;
    assign hour_out       = time_reg.hour;
    assign weekday_out    = time_reg.weekday;
    assign day_out        = time_reg.day;
    assign month_out      = time_reg.month;
    assign year_out       = time_reg.year;
    assign century_out    = time_reg.century;
    assign resync_request = out_resync_reg;
    assign tick_event     = out_tick_reg;

endmodule

FILE: dv/rtc_calendar_counter_checker.sv
`timescale 1ns / 1ps
// Checker for the calendar counter: keeps its own copy of the time and load formats,
// predicts one result word per accepted input word and compares each result field by field.
// Depends on rtc_pkg for the time, raw-byte and format types.

module rtc_calendar_counter_checker
    import rtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       operation,
    input  logic [7:0] raw_second,
    input  logic [7:0] raw_minute,
    input  logic [7:0] raw_hour,
    input  logic [7:0] raw_weekday,
    input  logic [7:0] raw_day,
    input  logic [7:0] raw_month,
    input  logic [7:0] raw_year,
    input  logic [7:0] raw_century,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [5:0] second_out,
    input  logic [5:0] minute_out,
    input  logic [4:0] hour_out,
    input  logic [2:0] weekday_out,
    input  logic [4:0] day_out,
    input  logic [3:0] month_out,
    input  logic [6:0] year_out,
    input  logic [6:0] century_out,
    input  logic       resync_request,
    input  logic       tick_event,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic       cfg_data,
    output int         error_count,
    output int         pending_words,
    output int         checked_words,
    output int         load_words,
    output int         day_rollovers
);

    // One result word: the time after an input word plus its two flags.
    typedef struct packed {
        rtc_time_t stamp;
        logic      resync;
        logic      tick;
    } clock_reading_t;

    localparam rtc_time_t TIME_AT_RESET = '{second: 6'd0, minute: 6'd0, hour: 5'd0,
                                            weekday: 3'd1, day: 5'd1, month: 4'd1,
                                            year: 7'd0, century: 7'd0};

    clock_reading_t expected_readings[$];
    rtc_time_t      clock_now = TIME_AT_RESET;
    rtc_mode_t      load_format = '0;

    function automatic int bcd_value(int b);
        return ((b >> 4) & 15) * 10 + (b & 15);
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Year 0 of a century is a leap year only when the century is a multiple of four.
    function automatic bit leap_year(int year, int century);
        if (year % 4 != 0)
            return 1'b0;
        if (year != 0)
            return 1'b1;
        return century % 4 == 0;
    endfunction

    function automatic int month_days(int month, int year, int century);
        case (month)
            2:          return leap_year(year, century) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    // Load: strip the PM flag, convert BCD, move to 24-hour form, then clamp every field.
    function automatic rtc_time_t decode_raw(rtc_raw_t raw, rtc_mode_t mode);
        int        v[8];
        logic      pm;
        rtc_time_t t;
        v[0] = int'(raw.second);
        v[1] = int'(raw.minute);
        v[2] = int'(raw.hour);
        v[3] = int'(raw.weekday);
        v[4] = int'(raw.day);
        v[5] = int'(raw.month);
        v[6] = int'(raw.year);
        v[7] = int'(raw.century);
        pm = 1'b0;
        if (mode.twelve_hour)
        begin
            pm = raw.hour[7];
            v[2] = v[2] & 'h7F;
        end
        if (mode.bcd)
        begin
            for (int i = 0; i < 8; i++)
                v[i] = bcd_value(v[i]);
        end
        if (mode.twelve_hour)
        begin
            if (pm && v[2] != 12)
                v[2] += 12;
            else if (!pm && v[2] == 12)
                v[2] = 0;
        end
        t.second  = 6'(clamp(v[0], 0, 59));
        t.minute  = 6'(clamp(v[1], 0, 59));
        t.hour    = 5'(clamp(v[2], 0, 23));
        t.weekday = 3'(clamp(v[3], 1, 7));
        t.day     = 5'(clamp(v[4], 1, 31));
        t.month   = 4'(clamp(v[5], 1, 12));
        t.year    = 7'(clamp(v[6], 0, 99));
        t.century = 7'(clamp(v[7], 0, 99));
        return t;
    endfunction

    // Tick: one second forward with the full cascade up to a wrapping century.
    function automatic rtc_time_t advance_second(rtc_time_t t, output logic resync);
        rtc_time_t n;
        n = t;
        resync = (t.second == 6'd29);
        if (t.second != 6'd59)
            n.second = t.second + 6'd1;
        else
        begin
            n.second = 6'd0;
            if (t.minute != 6'd59)
                n.minute = t.minute + 6'd1;
            else
            begin
                n.minute = 6'd0;
                if (t.hour != 5'd23)
                    n.hour = t.hour + 5'd1;
                else
                begin
                    n.hour = 5'd0;
                    n.weekday = (t.weekday >= 3'd7) ? 3'd1 : t.weekday + 3'd1;
                    // A loaded day past the month end still rolls to the first of next month.
                    if (int'(t.day) < month_days(int'(t.month), int'(t.year),
                                                 int'(t.century)))
                        n.day = t.day + 5'd1;
                    else
                    begin
                        n.day = 5'd1;
                        if (t.month < 4'd12)
                            n.month = t.month + 4'd1;
                        else
                        begin
                            n.month = 4'd1;
                            if (t.year < 7'd99)
                                n.year = t.year + 7'd1;
                            else
                            begin
                                n.year = 7'd0;
                                n.century = (t.century >= 7'd99) ? 7'd0 : t.century + 7'd1;
                            end
                        end
                    end
                end
            end
        end
        return n;
    endfunction

    function automatic string describe_reading(clock_reading_t r);
        return $sformatf({"%02d:%02d:%02d wd %0d day %0d month %0d",
                          " year %0d century %0d resync %0b tick %0b"},
                         r.stamp.hour, r.stamp.minute, r.stamp.second, r.stamp.weekday,
                         r.stamp.day, r.stamp.month, r.stamp.year, r.stamp.century,
                         r.resync, r.tick);
    endfunction

    function automatic bit fields_match(clock_reading_t want, clock_reading_t seen);
        return seen.stamp.second  === want.stamp.second  &&
               seen.stamp.minute  === want.stamp.minute  &&
               seen.stamp.hour    === want.stamp.hour    &&
               seen.stamp.weekday === want.stamp.weekday &&
               seen.stamp.day     === want.stamp.day     &&
               seen.stamp.month   === want.stamp.month   &&
               seen.stamp.year    === want.stamp.year    &&
               seen.stamp.century === want.stamp.century &&
               seen.resync        === want.resync        &&
               seen.tick          === want.tick;
    endfunction

    // Watch configuration writes, results and accepted words on every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        clock_reading_t want;
        clock_reading_t seen;
        logic           resync;
        rtc_time_t      next_time;
        rtc_raw_t       raw;
        if (!rst_n)
        begin
            clock_now = TIME_AT_RESET;
            load_format = '0;
            expected_readings.delete();
            pending_words = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_TWELVE_HOUR)
                    load_format.twelve_hour = cfg_data;
                else
                    load_format.bcd = cfg_data;
            end

            // Compare a result word against the oldest prediction.
            if (out_valid && !out_stall)
            begin
                seen = '{stamp: '{second: second_out, minute: minute_out, hour: hour_out,
                                  weekday: weekday_out, day: day_out, month: month_out,
                                  year: year_out, century: century_out},
                         resync: resync_request, tick: tick_event};
                checked_words++;
                if (expected_readings.size() == 0)
                begin
                    if (error_count < 10)
                        $display("[%0t] result word with nothing expected: %s",
                                 $realtime, describe_reading(seen));
                    error_count++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (!fields_match(want, seen))
                    begin
                        if (error_count < 10)
                            $display("[%0t] result mismatch\n  expected %s\n  actual   %s",
                                     $realtime, describe_reading(want), describe_reading(seen));
                        error_count++;
                    end
                end
            end

            // Predict the result of an accepted input word.
            if (in_valid && !in_stall)
            begin
                if (operation == OP_TICK)
                begin
                    next_time = advance_second(clock_now, resync);
                    if (next_time.day != clock_now.day)
                        day_rollovers++;
                    want = '{stamp: next_time, resync: resync, tick: 1'b1};
                end
                else
                begin
                    raw = '{second: raw_second, minute: raw_minute, hour: raw_hour,
                            weekday: raw_weekday, day: raw_day, month: raw_month,
                            year: raw_year, century: raw_century};
                    next_time = decode_raw(raw, load_format);
                    load_words++;
                    want = '{stamp: next_time, resync: 1'b0, tick: 1'b0};
                end
                clock_now = next_time;
                expected_readings.push_back(want);
            end
            pending_words = expected_readings.size();
        end
    end

endmodule

FILE: dv/rtc_calendar_counter_test.sv
`timescale 1ns / 1ps
// Top of the calendar counter testbench: clock, reset, stimulus, stalls and the verdict.
// Depends on rtc_pkg, the block rtc_calendar_counter and rtc_calendar_counter_checker.

module rtc_calendar_counter_test;
    import rtc_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       operation = OP_TICK;
    logic [7:0] raw_second = 8'd0;
    logic [7:0] raw_minute = 8'd0;
    logic [7:0] raw_hour = 8'd0;
    logic [7:0] raw_weekday = 8'd0;
    logic [7:0] raw_day = 8'd0;
    logic [7:0] raw_month = 8'd0;
    logic [7:0] raw_year = 8'd0;
    logic [7:0] raw_century = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [5:0] second_out;
    logic [5:0] minute_out;
    logic [4:0] hour_out;
    logic [2:0] weekday_out;
    logic [4:0] day_out;
    logic [3:0] month_out;
    logic [6:0] year_out;
    logic [6:0] century_out;
    logic       resync_request;
    logic       tick_event;
    logic       cfg_write = 1'b0;
    logic       cfg_index = CFG_TWELVE_HOUR;
    logic       cfg_data = 1'b0;

    int         error_count;
    int         pending_words;
    int         checked_words;
    int         load_words;
    int         day_rollovers;

    // Stimulus controls; long_hold_cycles and stall_noise are shared with the receiver process.
    int         long_hold_cycles = 0;
    bit         stall_noise = 1'b0;
    bit         sender_gaps = 1'b0;
    rtc_mode_t  load_format = '0;
    int         format_changes = 0;

    rtc_calendar_counter dut (.*);

    rtc_calendar_counter_checker calendar_check (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #3_000_000;
        $display("rtc_calendar_counter_test failed");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold when asked for.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (long_hold_cycles) @(negedge clk);
                long_hold_cycles = 0;
                out_stall <= 1'b0;
            end
            else if (stall_noise && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one word and return at the falling edge after it was taken.
    task automatic send_word(logic op, rtc_raw_t raw);
        in_valid    <= 1'b1;
        operation   <= op;
        raw_second  <= raw.second;
        raw_minute  <= raw.minute;
        raw_hour    <= raw.hour;
        raw_weekday <= raw.weekday;
        raw_day     <= raw.day;
        raw_month   <= raw.month;
        raw_year    <= raw.year;
        raw_century <= raw.century;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Ticks carry random bytes, which the block must ignore.
    task automatic send_tick();
        send_word(OP_TICK, rtc_raw_t'({$urandom(), $urandom()}));
    endtask

    task automatic pause_input(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic maybe_gap();
        if (sender_gaps && $urandom_range(0, 7) == 0)
            pause_input($urandom_range(1, 15));
    endtask

    function automatic logic [7:0] encode_byte(int v);
        return load_format.bcd ? 8'((v / 10) * 16 + v % 10) : 8'(v);
    endfunction

    // Load a well-formed time, encoded in the current load format.
    task automatic load_time(int s, int m, int h, int wd, int d, int mo, int y, int c);
        rtc_raw_t raw;
        int       h12;
        h12 = (h % 12 == 0) ? 12 : h % 12;
        raw.second  = encode_byte(s);
        raw.minute  = encode_byte(m);
        raw.weekday = encode_byte(wd);
        raw.day     = encode_byte(d);
        raw.month   = encode_byte(mo);
        raw.year    = encode_byte(y);
        raw.century = encode_byte(c);
        if (load_format.twelve_hour)
            raw.hour = encode_byte(h12) | (h >= 12 ? 8'h80 : 8'h00);
        else
            raw.hour = encode_byte(h);
        send_word(OP_LOAD, raw);
    endtask

    task automatic write_register(logic index, logic value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Change the load formats only once every result has come back.
    task automatic set_format(logic twelve, logic bcd);
        in_valid <= 1'b0;
        while (pending_words != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        write_register(CFG_TWELVE_HOUR, twelve);
        write_register(CFG_BCD, bcd);
        load_format = '{twelve_hour: twelve, bcd: bcd};
        format_changes++;
    endtask

    // Mostly ticks; loads are either raw noise or times biased toward a rollover.
    task automatic random_item();
        int s;
        if ($urandom_range(0, 15) != 0)
            send_tick();
        else if ($urandom_range(0, 3) == 0)
            send_word(OP_LOAD, rtc_raw_t'({$urandom(), $urandom()}));
        else
        begin
            case ($urandom_range(0, 3))
                0:       s = $urandom_range(0, 59);
                1:       s = $urandom_range(25, 29);
                default: s = $urandom_range(50, 59);
            endcase
            load_time(s,
                      $urandom_range(0, 1) ? 59 : $urandom_range(0, 59),
                      $urandom_range(0, 1) ? 23 : $urandom_range(0, 23),
                      $urandom_range(1, 7),
                      $urandom_range(0, 1) ? $urandom_range(27, 31) : $urandom_range(1, 31),
                      $urandom_range(0, 2) == 0 ? 12 : $urandom_range(1, 12),
                      $urandom_range(0, 2) == 0 ? 99 : $urandom_range(0, 99),
                      $urandom_range(0, 2) == 0 ? 99 : $urandom_range(0, 99));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Binary, 24-hour: clamping at both ends, resync, cascades and leap years.
        set_format(1'b0, 1'b0);
        send_tick();
        send_word(OP_LOAD, '0);
        send_word(OP_LOAD, '1);
        load_time(29, 59, 23, 3, 15, 6, 24, 20);
        send_tick();
        load_time(59, 59, 23, 7, 31, 12, 99, 99);
        send_tick();
        load_time(59, 59, 23, 2, 28, 2, 0, 20);
        send_tick();
        load_time(59, 59, 23, 2, 28, 2, 0, 19);
        send_tick();
        load_time(59, 59, 23, 5, 31, 2, 5, 20);
        send_tick();

        // 12-hour binary: noon, midnight and an afternoon hour.
        set_format(1'b1, 1'b0);
        send_word(OP_LOAD, '{8'd10, 8'd20, 8'h8C, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7});
        send_word(OP_LOAD, '{8'd10, 8'd20, 8'h0C, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7});
        send_word(OP_LOAD, '{8'd10, 8'd20, 8'h85, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7});

        // BCD 24-hour: top of every range, then digits above nine.
        set_format(1'b0, 1'b1);
        send_word(OP_LOAD, '{8'h59, 8'h59, 8'h23, 8'h07, 8'h31, 8'h12, 8'h99, 8'h99});
        send_tick();
        send_word(OP_LOAD, '{8'hAF, 8'hFA, 8'hFF, 8'h0A, 8'hA0, 8'h1F, 8'hFF, 8'hF9});

        // BCD 12-hour: PM noon and AM midnight.
        set_format(1'b1, 1'b1);
        send_word(OP_LOAD, '{8'h00, 8'h30, 8'h92, 8'h01, 8'h15, 8'h08, 8'h42, 8'h20});
        send_word(OP_LOAD, '{8'h00, 8'h30, 8'h12, 8'h01, 8'h15, 8'h08, 8'h42, 8'h20});

        // Random segments, each with its own formats; the last one runs without idling.
        for (int seg = 0; seg < 8; seg++)
        begin
            if (seg > 0)
                set_format(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sender_gaps = (seg != 7);
            stall_noise = (seg != 7);
            for (int k = 0; k < 235; k++)
            begin
                if (seg == 0 && k == 40)
                    long_hold_cycles = 80;
                random_item();
                if (!(seg == 0 && k >= 40 && k < 80))
                    maybe_gap();
            end
        end

        in_valid <= 1'b0;
        while (pending_words != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Checked %0d result words (%0d loads, %0d day rollovers)",
                 checked_words, load_words, day_rollovers);
        $display("over %0d format settings.", format_changes);
        if (error_count == 0)
            $display("rtc_calendar_counter_test passed");
        else
            $display("rtc_calendar_counter_test failed");
        $finish;
    end

endmodule

FILE: sim.f
src/rtc_pkg.sv
src/rtc_load_decode.sv
src/rtc_tick_advance.sv
src/rtc_calendar_counter.sv
dv/rtc_calendar_counter_checker.sv
dv/rtc_calendar_counter_test.sv
